// ----- rtl/core/lpa_pkg.sv -----
// Package for the patience-sort LIS block: sizes, operation and shape codes,
// controller states and the command/status structs between controller and datapath.
// No dependencies.
`timescale 1ns / 1ps

package lpa_pkg;

  localparam int MAX_CARDS   = 64;
  localparam int IDX_W       = $clog2(MAX_CARDS);
  localparam int CNT_W       = IDX_W + 1;
  localparam int DIM_W       = 32;
  localparam int AREA_W      = 2 * DIM_W;
  localparam int TRI_DIVISOR = 2;

  typedef enum logic [1:0] {
    OP_ADD   = 2'd0,
    OP_COUNT = 2'd1,
    OP_SEQ   = 2'd2,
    OP_ALT   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    SHP_SQUARE = 2'd0,
    SHP_RECT   = 2'd1,
    SHP_TRI    = 2'd2,
    SHP_ALT    = 2'd3
  } shape_t;

  typedef struct packed {
    logic [1:0]       shape;
    logic [DIM_W-1:0] first;
    logic [DIM_W-1:0] second;
  } card_t;

  typedef enum logic [12:0] {
    S_IDLE     = 13'b0000000000001,
    S_AREA     = 13'b0000000000010,
    S_SRCH_RD  = 13'b0000000000100,
    S_SRCH_CMP = 13'b0000000001000,
    S_COMMIT   = 13'b0000000010000,
    S_RESP     = 13'b0000000100000,
    S_Q_TAIL   = 13'b0000001000000,
    S_Q_SEED   = 13'b0000010000000,
    S_WALK_WR  = 13'b0000100000000,
    S_WALK_NXT = 13'b0001000000000,
    S_OUT_OB   = 13'b0010000000000,
    S_OUT_CARD = 13'b0100000000000,
    S_OUT_EMIT = 13'b1000000000000
  } state_t;

  typedef struct packed {
    logic latch;       // capture input transaction, init search bounds
    logic drop;        // store full: set overflow
    logic area;        // register area key
    logic srch_rd;     // read tail area at midpoint
    logic srch_cmp;    // narrow search bounds
    logic pred_rd;     // read tail card of previous pile
    logic commit;      // write card, links, tails
    logic walk_init;   // read tail card of last pile
    logic walk_seed;   // load walk cursor
    logic walk_wr;     // store cursor in order buffer, read its predecessor
    logic walk_next;   // follow predecessor link
    logic ob_rd;       // read order buffer entry
    logic card_rd;     // read card store
    logic emit_card;   // present one sequence card
    logic emit_plain;  // present a result with no card
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
    logic search_done;
    logic walk_done;
    logic out_last;
  } sts_t;

endpackage

// ----- rtl/core/lpa_ctrl.sv -----
// Controller FSM for the patience-sort LIS block.
// Depends on lpa_pkg; drives lpa_datapath through cmd_t, reads sts_t.
`timescale 1ns / 1ps

module lpa_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [1:0]    operation,
  input  lpa_pkg::sts_t sts,
  output lpa_pkg::cmd_t cmd,
  output logic          busy
);
  import lpa_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.latch = 1'b1;
          if (operation == OP_ADD) begin
            if (sts.full) begin
              cmd.drop   = 1'b1;
              state_next = S_RESP;
            end else begin
              state_next = S_AREA;
            end
          end else if (operation == OP_SEQ && !sts.empty) begin
            state_next = S_Q_TAIL;
          end else begin
            state_next = S_RESP;
          end
        end
      end
      S_AREA: begin
        cmd.area   = 1'b1;
        state_next = S_SRCH_RD;
      end
      S_SRCH_RD: begin
        if (sts.search_done) begin
          cmd.pred_rd = 1'b1;
          state_next  = S_COMMIT;
        end else begin
          cmd.srch_rd = 1'b1;
          state_next  = S_SRCH_CMP;
        end
      end
      S_SRCH_CMP: begin
        cmd.srch_cmp = 1'b1;
        state_next   = S_SRCH_RD;
      end
      S_COMMIT: begin
        cmd.commit = 1'b1;
        state_next = S_RESP;
      end
      S_RESP: begin
        cmd.emit_plain = 1'b1;
        state_next     = S_IDLE;
      end
      S_Q_TAIL: begin
        cmd.walk_init = 1'b1;
        state_next    = S_Q_SEED;
      end
      S_Q_SEED: begin
        cmd.walk_seed = 1'b1;
        state_next    = S_WALK_WR;
      end
      S_WALK_WR: begin
        cmd.walk_wr = 1'b1;
        state_next  = S_WALK_NXT;
      end
      S_WALK_NXT: begin
        cmd.walk_next = 1'b1;
        state_next    = sts.walk_done ? S_OUT_OB : S_WALK_WR;
      end
      S_OUT_OB: begin
        cmd.ob_rd  = 1'b1;
        state_next = S_OUT_CARD;
      end
      S_OUT_CARD: begin
        cmd.card_rd = 1'b1;
        state_next  = S_OUT_EMIT;
      end
      S_OUT_EMIT: begin
        cmd.emit_card = 1'b1;
        state_next    = sts.out_last ? S_IDLE : S_OUT_OB;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign busy = (state != S_IDLE);

  a_onehot_state: assert property (@(posedge clk) disable iff (rst) $onehot(state))
    else $error("controller state not one-hot");
  a_search_not_empty_walk: assert property (@(posedge clk) disable iff (rst)
    (state == S_Q_TAIL) |-> !sts.empty)
    else $error("sequence walk started on empty pile set");
  a_emit_ends_busy: assert property (@(posedge clk) disable iff (rst)
    cmd.emit_plain |=> !busy)
    else $error("plain result did not return to idle");

endmodule

// ----- rtl/core/lpa_datapath.sv -----
// Datapath for the patience-sort LIS block: area multiplier, binary search over
// pile tails, card/link/tail/order memories and the result register. Depends on lpa_pkg.
`timescale 1ns / 1ps

module lpa_datapath (
  input  logic                      clk,
  input  logic                      rst,
  input  lpa_pkg::cmd_t             cmd,
  output lpa_pkg::sts_t             sts,
  input  logic [1:0]                shape,
  input  logic [lpa_pkg::DIM_W-1:0] first_dim,
  input  logic [lpa_pkg::DIM_W-1:0] second_dim,
  output logic                      done,
  output logic [lpa_pkg::CNT_W-1:0] seq_length,
  output logic                      card_valid,
  output logic [1:0]                shape_out,
  output logic [lpa_pkg::DIM_W-1:0] first_dim_out,
  output logic [lpa_pkg::DIM_W-1:0] second_dim_out,
  output logic                      overflow,
  output logic                      last
);
  import lpa_pkg::*;

  // control state
  logic [CNT_W-1:0]  length_count;
  logic [CNT_W-1:0]  cards_stored;
  logic              overflow_flag;

  // working registers
  logic [1:0]        shape_q;
  logic [DIM_W-1:0]  first_q;
  logic [DIM_W-1:0]  second_q;
  logic [AREA_W-1:0] key;
  logic [CNT_W-1:0]  lo;
  logic [CNT_W-1:0]  hi;
  logic [CNT_W-1:0]  idx;
  logic [IDX_W-1:0]  cur;

  // memories and their registered read data
  card_t             card_mem [MAX_CARDS];
  logic [AREA_W-1:0] tail_area_mem [MAX_CARDS];
  logic [IDX_W-1:0]  tail_card_mem [MAX_CARDS];
  logic [IDX_W-1:0]  pred_mem [MAX_CARDS];
  logic [IDX_W-1:0]  order_mem [MAX_CARDS];
  card_t             card_rd;
  logic [AREA_W-1:0] tail_area_rd;
  logic [IDX_W-1:0]  tail_card_rd;
  logic [IDX_W-1:0]  pred_rd;
  logic [IDX_W-1:0]  order_rd;

  logic [CNT_W:0]    mid_sum;
  logic [CNT_W-1:0]  mid;
  logic [CNT_W-1:0]  pos_m1;
  logic [CNT_W-1:0]  len_m1;
  logic [CNT_W-1:0]  idx_m1;
  logic [CNT_W-1:0]  idx_p1;
  logic [IDX_W-1:0]  tc_raddr;
  logic [IDX_W-1:0]  slot;
  logic [1:0]        shape_n;
  logic [DIM_W-1:0]  second_n;
  logic [DIM_W-1:0]  mul_b;
  logic [AREA_W-1:0] prod;

  assign mid_sum  = {1'b0, lo} + {1'b0, hi};
  assign mid      = mid_sum[CNT_W:1];
  assign pos_m1   = lo - 1'b1;
  assign len_m1   = length_count - 1'b1;
  assign idx_m1   = idx - 1'b1;
  assign idx_p1   = idx + 1'b1;
  assign tc_raddr = cmd.walk_init ? len_m1[IDX_W-1:0] : pos_m1[IDX_W-1:0];
  assign slot     = cards_stored[IDX_W-1:0];

  // shape code three folds to triangle; a square carries no second dimension
  always_comb begin
    case (shape)
      SHP_SQUARE: shape_n = SHP_SQUARE;
      SHP_RECT:   shape_n = SHP_RECT;
      default:    shape_n = SHP_TRI;
    endcase
  end
  assign second_n = (shape == SHP_SQUARE) ? '0 : second_dim;

  assign mul_b = (shape_q == SHP_SQUARE) ? first_q : second_q;
  assign prod  = AREA_W'(first_q) * AREA_W'(mul_b);

  assign sts.full        = (cards_stored == CNT_W'(MAX_CARDS));
  assign sts.empty       = (length_count == '0);
  assign sts.search_done = (lo == hi);
  assign sts.walk_done   = (idx == '0);
  assign sts.out_last    = (idx_p1 == length_count);

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      length_count  <= '0;
      cards_stored  <= '0;
      overflow_flag <= 1'b0;
      done          <= 1'b0;
    end else begin
      done <= cmd.emit_card | cmd.emit_plain;
      if (cmd.drop) begin
        overflow_flag <= 1'b1;
      end
      if (cmd.commit) begin
        cards_stored <= cards_stored + 1'b1;
        if (lo == length_count) begin
          length_count <= length_count + 1'b1;
        end
      end
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      shape_q  <= shape_n;
      first_q  <= first_dim;
      second_q <= second_n;
      lo       <= '0;
      hi       <= length_count;
    end
    if (cmd.area) begin
      key <= (shape_q == SHP_TRI) ? prod / AREA_W'(TRI_DIVISOR) : prod;
    end
    if (cmd.srch_cmp) begin
      if (tail_area_rd < key) begin
        lo <= mid + 1'b1;
      end else begin
        hi <= mid;
      end
    end
    if (cmd.walk_init) begin
      idx <= length_count;
    end
    if (cmd.walk_seed) begin
      cur <= tail_card_rd;
    end
    if (cmd.walk_wr) begin
      idx <= idx_m1;
    end
    if (cmd.walk_next) begin
      cur <= pred_rd;
    end
    if (cmd.emit_card) begin
      idx <= idx_p1;
    end
  end

  // memories
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      card_mem[slot] <= '{shape: shape_q, first: first_q, second: second_q};
    end
    if (cmd.card_rd) begin
      card_rd <= card_mem[order_rd];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      tail_area_mem[lo[IDX_W-1:0]] <= key;
    end
    if (cmd.srch_rd) begin
      tail_area_rd <= tail_area_mem[mid[IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      tail_card_mem[lo[IDX_W-1:0]] <= slot;
    end
    if (cmd.pred_rd || cmd.walk_init) begin
      tail_card_rd <= tail_card_mem[tc_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      pred_mem[slot] <= (lo == '0) ? '0 : tail_card_rd;
    end
    if (cmd.walk_wr) begin
      pred_rd <= pred_mem[cur];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.walk_wr) begin
      order_mem[idx_m1[IDX_W-1:0]] <= cur;
    end
    if (cmd.ob_rd) begin
      order_rd <= order_mem[idx[IDX_W-1:0]];
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.emit_card || cmd.emit_plain) begin
      seq_length     <= length_count;
      overflow       <= overflow_flag;
      card_valid     <= cmd.emit_card;
      shape_out      <= cmd.emit_card ? card_rd.shape : 2'b00;
      first_dim_out  <= cmd.emit_card ? card_rd.first : '0;
      second_dim_out <= cmd.emit_card ? card_rd.second : '0;
      last           <= cmd.emit_card ? sts.out_last : 1'b1;
    end
  end

  a_len_le_stored: assert property (@(posedge clk) disable iff (rst)
    length_count <= cards_stored)
    else $error("pile count exceeds stored cards");
  a_commit_counts: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |=> cards_stored == $past(cards_stored) + 1'b1)
    else $error("commit did not advance card count");
  a_search_bounds: assert property (@(posedge clk) disable iff (rst)
    cmd.srch_rd |-> (lo < hi) && (hi <= length_count))
    else $error("search bounds out of order");
  a_drop_sets_flag: assert property (@(posedge clk) disable iff (rst)
    cmd.drop |=> overflow_flag)
    else $error("dropped card did not set overflow");

endmodule

// ----- rtl/core/lis_patience_by_area.sv -----
// Top level of the patience-sort LIS block: controller plus datapath.
// Depends on lpa_pkg, lpa_ctrl and lpa_datapath.
`timescale 1ns / 1ps

// A transaction is taken when start is high and busy is low. Every transaction
// gives one or more results, each shown for exactly one cycle with done high;
// the receiver cannot stall, so results must be captured as they come. An add
// or a pile-count query gives one result with last set. A subsequence query
// gives one result per card of the longest strictly increasing run (by area),
// first to last, last set on the final one; with no piles it gives a single
// cardless result. An add does the area multiply, then a binary search over
// the pile tails, each step a registered tail-area read and a compare, then
// the commit and the result; a dropped add or a count query goes straight to
// its result. A subsequence query first walks the predecessor links back into
// the order buffer, then for each card does an order-buffer read, a card-store
// read and the emit.
// Results come in the cycle after the controller issues them, and busy may
// already be low then; a new start can overlap the final result.
// The store holds 64 cards; beyond that adds are dropped and overflow
// stays set until reset.
module lis_patience_by_area (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  output logic                      busy,
  input  logic [1:0]                operation,
  input  logic [1:0]                shape,
  input  logic [lpa_pkg::DIM_W-1:0] first_dim,
  input  logic [lpa_pkg::DIM_W-1:0] second_dim,
  output logic                      done,
  output logic [lpa_pkg::CNT_W-1:0] seq_length,
  output logic                      card_valid,
  output logic [1:0]                shape_out,
  output logic [lpa_pkg::DIM_W-1:0] first_dim_out,
  output logic [lpa_pkg::DIM_W-1:0] second_dim_out,
  output logic                      overflow,
  output logic                      last
);
  import lpa_pkg::*;

  cmd_t cmd;  // controller -> datapath commands
  sts_t sts;  // datapath -> controller status

  lpa_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .operation (operation),
    .sts       (sts),
    .cmd       (cmd),
    .busy      (busy)
  );

  // datapath: input fields are captured on the accepting edge via cmd.latch
  lpa_datapath u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .sts            (sts),
    .shape          (shape),
    .first_dim      (first_dim),
    .second_dim     (second_dim),
    .done           (done),
    .seq_length     (seq_length),
    .card_valid     (card_valid),
    .shape_out      (shape_out),
    .first_dim_out  (first_dim_out),
    .second_dim_out (second_dim_out),
    .overflow       (overflow),
    .last           (last)
  );

endmodule

// ----- tb/tb_lis_patience_by_area.sv -----
// Self-checking bench for lis_patience_by_area: a directed table, then random card adds
// and queries, every result compared with an in-bench patience-sort model of the block.
// Depends on lpa_pkg and the lis_patience_by_area RTL.
`timescale 1ns / 1ps

module tb_lis_patience_by_area;
  import lpa_pkg::*;

  localparam int CLK_HALF    = 4;        // 8 ns period
  localparam int RAND_ITEMS  = 360;
  // Slowest legal run: 380 transactions, each a 64-card walk plus the sender's idle
  // gaps; the limit is set well above it.
  localparam int CYCLE_LIMIT = 1000000;
  localparam int DRAIN       = 40;       // quiet cycles after the final result
  localparam int QUIET_FIRST = 120;      // random transactions sent back to back
  localparam int QUIET_LAST  = 219;

  // One result as the block shows it while done is high.
  typedef struct {
    logic [CNT_W-1:0] len;
    logic             has_card;
    logic [1:0]       shp;
    logic [DIM_W-1:0] first;
    logic [DIM_W-1:0] second;
    logic             ovf;
    logic             fin;
  } pile_report_t;

  // Directed stimulus row; typed rows carry a plain result written in by hand.
  typedef struct {
    op_t              op;
    shape_t           shp;
    logic [DIM_W-1:0] first;
    logic [DIM_W-1:0] second;
    bit               typed;
    logic [CNT_W-1:0] t_len;
  } stim_row_t;

  logic             clk;
  logic             rst;
  logic             start;
  logic             busy;
  logic [1:0]       operation;
  logic [1:0]       shape;
  logic [DIM_W-1:0] first_dim;
  logic [DIM_W-1:0] second_dim;
  logic             done;
  logic [CNT_W-1:0] seq_length;
  logic             card_valid;
  logic [1:0]       shape_out;
  logic [DIM_W-1:0] first_dim_out;
  logic [DIM_W-1:0] second_dim_out;
  logic             overflow;
  logic             last;

  // Model state: card store, pile tails and the predecessor link of each card.
  logic [1:0]        deck_shape  [MAX_CARDS];
  logic [DIM_W-1:0]  deck_first  [MAX_CARDS];
  logic [DIM_W-1:0]  deck_second [MAX_CARDS];
  logic [AREA_W-1:0] deck_area   [MAX_CARDS];
  logic [IDX_W-1:0]  link_prev   [MAX_CARDS];
  logic [IDX_W-1:0]  pile_tail   [MAX_CARDS];
  int                pile_count;
  int                deck_fill;
  bit                drop_seen;

  pile_report_t      pending_reports[$];   // results still owed by the block
  stim_row_t         directed_rows[$];
  logic [DIM_W-1:0]  ramp;                 // grows to build rising card runs

  int mismatches;
  int items_sent;
  int results_seen;
  int dropped_adds;
  int longest_walk;
  int cycle_count;

  lis_patience_by_area dut (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .operation      (operation),
    .shape          (shape),
    .first_dim      (first_dim),
    .second_dim     (second_dim),
    .done           (done),
    .seq_length     (seq_length),
    .card_valid     (card_valid),
    .shape_out      (shape_out),
    .first_dim_out  (first_dim_out),
    .second_dim_out (second_dim_out),
    .overflow       (overflow),
    .last           (last)
  );

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  // Watchdog: a hung handshake or a missing result ends the run here.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               pending_reports.size());
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic flag_mismatch(string msg);
    mismatches++;
    $display("[%0t] mismatch: %s", $time, msg);
  endtask

  // Area key: e*e, l*b, or (b*h)/2 truncated, all in 64 bits.
  function automatic logic [AREA_W-1:0] area_key(logic [1:0] shp, logic [DIM_W-1:0] a,
                                                 logic [DIM_W-1:0] b);
    logic [AREA_W-1:0] prod;
    prod = AREA_W'(a) * AREA_W'((shp == SHP_SQUARE) ? a : b);
    return (shp == SHP_TRI) ? prod / TRI_DIVISOR : prod;
  endfunction

  function automatic void push_report(bit has_card, int idx, bit fin);
    pile_report_t r;
    r.len      = CNT_W'(pile_count);
    r.has_card = has_card;
    r.shp      = has_card ? deck_shape[idx]  : 2'd0;
    r.first    = has_card ? deck_first[idx]  : '0;
    r.second   = has_card ? deck_second[idx] : '0;
    r.ovf      = drop_seen;
    r.fin      = fin;
    pending_reports.insert(pending_reports.size(), r);
  endfunction

  // Patience-sort step for one accepted transaction; queues the results it causes.
  function automatic void predict_patience(op_t op, shape_t shp_in, logic [DIM_W-1:0] a,
                                           logic [DIM_W-1:0] b);
    logic [1:0]        shp;
    logic [DIM_W-1:0]  b_kept;
    logic [AREA_W-1:0] key;
    int                pos;
    int                walk;
    int                i;
    int                chain [MAX_CARDS];
    if (op == OP_ADD) begin
      if (deck_fill >= MAX_CARDS) begin
        // store full: card dropped, only the sticky flag moves
        drop_seen = 1'b1;
        dropped_adds++;
      end else begin
        shp    = (shp_in == SHP_ALT) ? SHP_TRI : shp_in;
        b_kept = (shp == SHP_SQUARE) ? '0 : b;
        key    = area_key(shp, a, b_kept);
        // first pile whose tail is not below the new area
        pos = 0;
        while (pos < pile_count && deck_area[pile_tail[pos]] < key) pos++;
        deck_shape[deck_fill]  = shp;
        deck_first[deck_fill]  = a;
        deck_second[deck_fill] = b_kept;
        deck_area[deck_fill]   = key;
        link_prev[deck_fill]   = (pos > 0) ? pile_tail[pos - 1] : '0;
        pile_tail[pos]         = IDX_W'(deck_fill);
        if (pos == pile_count) pile_count++;
        deck_fill++;
      end
      push_report(1'b0, 0, 1'b1);
    end else if (op != OP_SEQ || pile_count == 0) begin
      // count query, code three, or a subsequence query with no piles
      push_report(1'b0, 0, 1'b1);
    end else begin
      // walk links back from the last pile's tail, then report first to last
      walk = pile_tail[pile_count - 1];
      for (i = pile_count - 1; i >= 0; i--) begin
        chain[i] = walk;
        walk     = link_prev[walk];
      end
      for (i = 0; i < pile_count; i++) push_report(1'b1, chain[i], i == pile_count - 1);
      if (pile_count > longest_walk) longest_walk = pile_count;
    end
  endfunction

  // Result monitor: the receiver cannot stall, so every done cycle is taken as it comes.
  always @(posedge clk) begin : result_check
    pile_report_t want;
    if (!rst && done) begin
      if (pending_reports.size() == 0) begin
        flag_mismatch($sformatf("result with nothing expected (seq_length %0d)", seq_length));
      end else begin
        want = pending_reports.pop_front();
        results_seen++;
        if (seq_length !== want.len)
          flag_mismatch($sformatf("seq_length %0d, want %0d", seq_length, want.len));
        if (card_valid !== want.has_card)
          flag_mismatch($sformatf("card_valid %0b, want %0b", card_valid, want.has_card));
        if (shape_out !== want.shp)
          flag_mismatch($sformatf("shape_out %0d, want %0d", shape_out, want.shp));
        if (first_dim_out !== want.first)
          flag_mismatch($sformatf("first_dim_out %0h, want %0h", first_dim_out, want.first));
        if (second_dim_out !== want.second)
          flag_mismatch($sformatf("second_dim_out %0h, want %0h", second_dim_out,
                                  want.second));
        if (overflow !== want.ovf)
          flag_mismatch($sformatf("overflow %0b, want %0b", overflow, want.ovf));
        if (last !== want.fin)
          flag_mismatch($sformatf("last %0b, want %0b", last, want.fin));
      end
    end
  end

  // Present one transaction at the falling edge and hold it until busy is seen low.
  task automatic send_transaction(op_t op, shape_t shp, logic [DIM_W-1:0] a,
                                  logic [DIM_W-1:0] b);
    @(negedge clk);
    start      <= 1'b1;
    operation  <= op;
    shape      <= shp;
    first_dim  <= a;
    second_dim <= b;
    do @(posedge clk); while (busy);
    items_sent++;
    predict_patience(op, shp, a, b);
  endtask

  // Sender idle cycles; the fields carry noise while start is low.
  task automatic hold_off(int cycles);
    repeat (cycles) begin
      @(negedge clk);
      start      <= 1'b0;
      operation  <= 2'($urandom);
      shape      <= 2'($urandom);
      first_dim  <= $urandom;
      second_dim <= $urandom;
    end
  endtask

  task automatic maybe_idle(bit allowed);
    if (allowed && $urandom_range(0, 99) < 6) hold_off($urandom_range(1, 4));
  endtask

  // Random transaction: mostly adds while the store has room, mostly queries after.
  // Most adds follow a rising area ramp so the piles grow deep; the rest are tiny
  // dimensions (ties, zero areas) or full 32-bit noise.
  task automatic pick_random(output op_t op, output shape_t shp,
                             output logic [DIM_W-1:0] a, output logic [DIM_W-1:0] b);
    int roll;
    roll = $urandom_range(0, 99);
    if (deck_fill < MAX_CARDS)
      op = (roll < 55) ? OP_ADD : (roll < 70) ? OP_COUNT : (roll < 95) ? OP_SEQ : OP_ALT;
    else
      op = (roll < 15) ? OP_ADD : (roll < 45) ? OP_COUNT : (roll < 92) ? OP_SEQ : OP_ALT;
    shp  = shape_t'($urandom_range(0, 3));
    roll = $urandom_range(0, 99);
    if (roll < 60) begin
      ramp = ramp + DIM_W'($urandom_range(0, 40));
      a    = ramp + DIM_W'($urandom_range(0, 3));
      // rect a*a and triangle (a*2a)/2 land on about the same area as a square
      b    = (shp == SHP_RECT) ? a : (shp == SHP_SQUARE) ? $urandom : 2 * a;
    end else if (roll < 80) begin
      a = $urandom_range(0, 15);
      b = $urandom_range(0, 15);
    end else begin
      a = $urandom;
      b = $urandom;
    end
  endtask

  function automatic void add_row(op_t op, shape_t shp, logic [DIM_W-1:0] a,
                                  logic [DIM_W-1:0] b, bit typed = 1'b0,
                                  logic [CNT_W-1:0] t_len = '0);
    stim_row_t r;
    r.op     = op;
    r.shp    = shp;
    r.first  = a;
    r.second = b;
    r.typed  = typed;
    r.t_len  = t_len;
    directed_rows.insert(directed_rows.size(), r);
  endfunction

  initial begin
    stim_row_t        row;
    pile_report_t     typed_rep;
    op_t              op;
    shape_t           shp;
    logic [DIM_W-1:0] a;
    logic [DIM_W-1:0] b;
    int               n;

    rst        = 1'b1;
    start      = 1'b0;
    operation  = OP_ADD;
    shape      = SHP_SQUARE;
    first_dim  = '0;
    second_dim = '0;
    pile_count = 0;
    deck_fill  = 0;
    drop_seen  = 1'b0;
    ramp       = 32'd16;

    // Directed table. Typed rows: queries on an empty block and the first add.
    add_row(OP_COUNT, SHP_SQUARE, '0, '0, 1'b1, 7'd0);            // count after reset
    add_row(OP_SEQ,   SHP_SQUARE, '0, '0, 1'b1, 7'd0);            // empty subsequence
    add_row(OP_ALT,   SHP_RECT,   '1, '1, 1'b1, 7'd0);            // code three = count
    add_row(OP_ADD,   SHP_SQUARE, '0, '1, 1'b1, 7'd1);            // area 0, breadth dropped
    add_row(OP_SEQ,   SHP_SQUARE, '0, '0);
    add_row(OP_ADD,   SHP_TRI,    32'd1, 32'd1);                  // (1*1)/2 = 0, a tie
    add_row(OP_ADD,   SHP_RECT,   32'd1, 32'd1);
    add_row(OP_ADD,   SHP_ALT,    32'd3, 32'd4);                  // shape three = triangle
    add_row(OP_ADD,   SHP_SQUARE, 32'd2, 32'd5);                  // area 4 replaces area 6
    add_row(OP_ADD,   SHP_RECT,   '1, '1);                        // largest area
    add_row(OP_ADD,   SHP_TRI,    '1, '1);                        // largest triangle
    add_row(OP_ADD,   SHP_SQUARE, '1, '0);                        // ties the largest area
    add_row(OP_SEQ,   SHP_TRI,    '0, '0);
    add_row(OP_COUNT, SHP_SQUARE, '0, '0);
    add_row(OP_ADD,   SHP_RECT,   32'd5, 32'd0);                  // zero breadth
    add_row(OP_ALT,   SHP_ALT,    '0, '0);
    add_row(OP_ADD,   SHP_RECT,   32'd2, 32'd3);
    add_row(OP_SEQ,   SHP_RECT,   '0, '0);
    add_row(OP_ADD,   SHP_TRI,    32'h8000_0000, 32'd2);
    add_row(OP_SEQ,   SHP_SQUARE, '1, '1);

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (directed_rows[k]) begin
      row = directed_rows[k];
      maybe_idle(1'b1);
      send_transaction(row.op, row.shp, row.first, row.second);
      if (row.typed) begin
        // typed rows give one result; it replaces the model's newest entry
        typed_rep = '{len: row.t_len, has_card: 1'b0, shp: 2'd0, first: '0, second: '0,
                      ovf: 1'b0, fin: 1'b1};
        pending_reports[pending_reports.size() - 1] = typed_rep;
      end
    end

    for (n = 0; n < RAND_ITEMS; n++) begin
      // twice the sender waits for the block to go fully quiet
      if (n == 60 || n == 250) begin
        hold_off(1);
        while (pending_reports.size() != 0) @(posedge clk);
      end
      maybe_idle(n < QUIET_FIRST || n > QUIET_LAST);
      pick_random(op, shp, a, b);
      send_transaction(op, shp, a, b);
    end

    hold_off(1);
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);

    $display("Ran %0d transactions (%0d directed), checked %0d results; %0d adds hit a full store.",
             items_sent, directed_rows.size(), results_seen, dropped_adds);
    $display("Deepest subsequence walked: %0d cards out of %0d stored.", longest_walk, deck_fill);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
